FILE: rtl/rfsr_pkg.sv
// ----------------------------------------------------------------------------
// rfsr_pkg: shared types and constants for the ring FIFO with read snapshot
// Holds the channel payload structs, command codes, controller states and
// the command/status bundles that run between controller and datapath.
// ----------------------------------------------------------------------------
package rfsr_pkg;

   localparam int unsigned FIELD_DATA_W = 32;
   localparam int unsigned COUNT_W      = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      CMD_PUT      = 2'd0,
      CMD_SNAPSHOT = 2'd1,
      CMD_GET      = 2'd2,
      CMD_COMMIT   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [FIELD_DATA_W-1:0]  put_data;
   } req_type;

   typedef struct packed {
      logic                     status;
      logic [FIELD_DATA_W-1:0]  read_data;
      logic [COUNT_W-1:0]       readable_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_rsp;
      logic rsp_from_ram;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    win_empty;
      logic    out_free;
   } ctrl_status_type;

endpackage

FILE: rtl/ring_fifo_snapshot_read.sv
// ----------------------------------------------------------------------------
// ring_fifo_snapshot_read: ring FIFO with a transactional read window
//
//   channel   ports                          carries
//   request   req_valid, req_stall, req_data  cmd, put_data
//   response  rsp_valid, rsp_stall, rsp_data  status, read_data, readable_count
//
// One request is worked at a time. Put, snapshot, commit and a failed get
// load their response in the execute state that follows the request
// transfer; a successful get reads the store there and loads its response in
// the read state from the registered store read. A new request is taken the
// cycle after the response is loaded, so a request is finished before the
// next is taken. A stalled response holds the sequencer until the result
// register frees up. Reset zeroes all pointers; the store is not cleared.
// ----------------------------------------------------------------------------
module ring_fifo_snapshot_read
   import rfsr_pkg::*;
#(
   parameter int unsigned DEPTH      = 256,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_cmd_type    ctl;
   ctrl_status_type stat;

   rfsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   rfsr_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/rfsr_ram.sv
// ----------------------------------------------------------------------------
// rfsr_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rfsr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rfsr_ctrl.sv
// ----------------------------------------------------------------------------
// rfsr_ctrl: command sequencer
// Takes one request at a time, runs it against the pointers and waits for
// the result register to be free before loading the response.
// ----------------------------------------------------------------------------
module rfsr_ctrl
   import rfsr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type stat,
   output ctrl_cmd_type    ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.cmd == CMD_GET && !stat.win_empty) begin
               state_in = ST_READ;
            end else if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctl.capture = req_valid;
         end
         ST_EXEC: begin
            // A successful get only starts the memory read here; every other
            // command finishes in this state once the result register is free.
            if (stat.cmd == CMD_GET && !stat.win_empty) begin
               ctl.execute = 1'b1;
            end else if (stat.out_free) begin
               ctl.execute  = 1'b1;
               ctl.load_rsp = 1'b1;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               ctl.load_rsp     = 1'b1;
               ctl.rsp_from_ram = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/rfsr_dpath.sv
// ----------------------------------------------------------------------------
// rfsr_dpath: pointers, word store and result register
// Holds the live and snapshot pointers, the ring storage and the response
// register that decouples the result channel from the request side.
// ----------------------------------------------------------------------------
module rfsr_dpath
   import rfsr_pkg::*;
#(
   parameter int unsigned DEPTH      = 256,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_data,
   input  ctrl_cmd_type    ctl,
   output ctrl_status_type stat,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   localparam int unsigned PTR_W   = $clog2(DEPTH);
   localparam int unsigned STORE_W = (DATA_WIDTH < FIELD_DATA_W) ? DATA_WIDTH : FIELD_DATA_W;
   localparam int unsigned NUM_W   = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

   cmd_type                 cmd_ff;
   logic [FIELD_DATA_W-1:0] put_data_ff;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]        srd_ptr_ff, srd_ptr_in;
   logic [PTR_W-1:0]        swr_ptr_ff, swr_ptr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [PTR_W-1:0]        wr_ptr_next;
   logic [PTR_W-1:0]        srd_ptr_next;
   logic                    full;
   logic                    win_empty;
   logic [PTR_W:0]          diff;
   logic [PTR_W-1:0]        used;
   logic [NUM_W-1:0]        used_wide;
   logic [COUNT_W-1:0]      count_sat;
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [STORE_W-1:0]      ram_rd_data;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_ptr_next  = ptr_inc(wr_ptr_ff);
   assign srd_ptr_next = ptr_inc(srd_ptr_ff);
   assign full         = (wr_ptr_next == rd_ptr_ff);
   assign win_empty    = (srd_ptr_ff == swr_ptr_ff);

   // Words between read and write pointer, modulo the ring size.
   assign diff      = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
   assign used      = diff[PTR_W-1:0] + (diff[PTR_W] ? PTR_W'(DEPTH) : '0);
   assign used_wide = NUM_W'(used);
   assign count_sat = (used_wide > NUM_W'(COUNT_MAX)) ? COUNT_MAX : used_wide[COUNT_W-1:0];

   assign ram_wr_en = ctl.execute && (cmd_ff == CMD_PUT) && !full;
   assign ram_rd_en = ctl.execute && (cmd_ff == CMD_GET) && !win_empty;

   rfsr_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (put_data_ff[STORE_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (srd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff      <= req_data.cmd;
         put_data_ff <= req_data.put_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         srd_ptr_ff   <= '0;
         swr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         srd_ptr_ff   <= srd_ptr_in;
         swr_ptr_ff   <= swr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      srd_ptr_in = srd_ptr_ff;
      swr_ptr_in = swr_ptr_ff;
      if (ctl.execute) begin
         unique case (cmd_ff)
            CMD_PUT: begin
               if (!full) begin
                  wr_ptr_in = wr_ptr_next;
               end
            end
            CMD_SNAPSHOT: begin
               srd_ptr_in = rd_ptr_ff;
               swr_ptr_in = wr_ptr_ff;
            end
            CMD_GET: begin
               if (!win_empty) begin
                  srd_ptr_in = srd_ptr_next;
               end
            end
            CMD_COMMIT: begin
               rd_ptr_in = srd_ptr_ff;
            end
            default: ;
         endcase
      end
   end

   // Result register: loaded by the controller, emptied by a transfer.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (ctl.rsp_from_ram) begin
            rsp_in.status         = 1'b0;
            rsp_in.read_data      = FIELD_DATA_W'(ram_rd_data);
            rsp_in.readable_count = '0;
         end else begin
            rsp_in.status         = ((cmd_ff == CMD_PUT) && full) ||
                                    ((cmd_ff == CMD_GET) && win_empty);
            rsp_in.read_data      = '0;
            rsp_in.readable_count = (cmd_ff == CMD_SNAPSHOT) ? count_sat : '0;
         end
      end
   end

   assign stat.cmd       = cmd_ff;
   assign stat.win_empty = win_empty;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
